/* rtl/spsl_pkg.sv */
// ----------------------------------------------------------------------------
// spsl_pkg
// Shared widths, register indexes, opcodes and interface structs for the
// servo position slew core.
// ----------------------------------------------------------------------------
package spsl_pkg;

  // Field widths
  localparam int PULSE_W    = 16;
  localparam int DELAY_W    = 8;
  localparam int POS_W      = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Stream payload widths; the data fields are padded to whole bytes
  localparam int IN_TDATA_W  = 8;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_PAD_W   = OUT_TDATA_W - PULSE_W - 2;

  // Default number of calibrated positions
  localparam int POSITIONS_DEF = 10;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_PULSE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLOSED_PULSE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_VALID    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_DELAY   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CLOSE_DELAY  = 3'd4;

  // Reset values of the delay registers
  localparam logic [DELAY_W-1:0] OPEN_DELAY_RST  = 8'd5;
  localparam logic [DELAY_W-1:0] CLOSE_DELAY_RST = 8'd2;

  // Item opcodes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_SET  = 1'b1;

  // Configuration register file contents
  typedef struct packed {
    logic [PULSE_W-1:0] open_pulse;
    logic [PULSE_W-1:0] closed_pulse;
    logic               calibration_valid;
    logic [DELAY_W-1:0] open_delay;
    logic [DELAY_W-1:0] close_delay;
  } cfg_t;

  // Item leaving the target pipeline for the slew stage
  typedef struct packed {
    logic               valid;
    logic               opcode;
    logic [PULSE_W-1:0] target;
    logic               span_up;
  } cmd_t;

endpackage

/* rtl/servo_position_slew_core.sv */
// ----------------------------------------------------------------------------
// servo_position_slew_core
// Slews a servo compare value toward calibrated positions, one count per step.
// ----------------------------------------------------------------------------
// Each input item is a millisecond tick or a set-position command; each gives
// exactly one result with the pulse value, a moving flag and a rejected flag.
// The core takes one item per clock while the result stream is not stalled;
// each item passes, in order, through an input register, a register after the
// reciprocal multiply that divides the calibrated span by the position count
// minus one, a register after the position offset and target, then the slew
// state and result register, which updates once per item and sets the rate.
// Program the calibration and delays only while no item is in flight.
module servo_position_slew_core #(
  parameter int POSITIONS = spsl_pkg::POSITIONS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // Input items
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [spsl_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // [3:0] position_index
  input  logic [spsl_pkg::IN_TUSER_W-1:0]   s_axis_tuser,  // [0] opcode
  // Result items
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [15:0] pulse_value, [16] moving, [17] rejected
  output logic [spsl_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // Configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [spsl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [spsl_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import spsl_pkg::*;

  cfg_t               cfg;
  cmd_t               cmd;
  logic               cmd_ready;
  logic               cmd_fire;
  logic [PULSE_W-1:0] pulse;
  logic               moving;
  logic               rejected;

  // Configuration registers
  spsl_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Target pipeline
  spsl_target #(
    .POSITIONS (POSITIONS)
  ) u_target (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_opcode (s_axis_tuser[0]),
    .in_pos    (s_axis_tdata[POS_W-1:0]),
    .cfg       (cfg),
    .cmd       (cmd),
    .cmd_ready (cmd_ready)
  );

  // Slew state and result register
  spsl_slew u_slew (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cmd_ready (cmd_ready),
    .cfg       (cfg),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .pulse     (pulse),
    .moving    (moving),
    .rejected  (rejected)
  );

  // Pack the result
  assign m_axis_tdata = {OUT_PAD_W'(0), rejected, moving, pulse};

  assign cmd_fire = cmd.valid && cmd_ready;

  // The pulse moves by at most one count per item
  a_pulse_single_step: assert property (@(posedge clk) disable iff (rst)
    cmd_fire |=> (pulse == $past(pulse)) ||
                 (pulse == $past(pulse) + PULSE_W'(1)) ||
                 (pulse == $past(pulse) - PULSE_W'(1)))
    else $error("pulse moved by more than one count");

  // Without an item reaching the slew stage the pulse holds
  a_pulse_hold: assert property (@(posedge clk) disable iff (rst)
    !cmd_fire |=> $stable(pulse))
    else $error("pulse changed without an item");

  // A stalled command at the slew stage holds its contents
  a_cmd_hold: assert property (@(posedge clk) disable iff (rst)
    cmd.valid && !cmd_ready |=> cmd.valid && $stable(cmd))
    else $error("stalled command changed");

  // Input back-pressure only when the target pipeline is full at its exit
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> cmd.valid && !cmd_ready && m_axis_tvalid)
    else $error("input stalled while the pipeline can move");

endmodule

/* rtl/spsl_cfg_regs.sv */
// ----------------------------------------------------------------------------
// spsl_cfg_regs
// Configuration register file: calibration pulses, calibration flag and the
// opening and closing step delays.
// ----------------------------------------------------------------------------
module spsl_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [spsl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [spsl_pkg::CFG_DATA_W-1:0]  cfg_data,
  output spsl_pkg::cfg_t                   cfg
);
  import spsl_pkg::*;

  // Writes are always taken
  assign cfg_ready = 1'b1;

  // Decode the write; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.open_pulse        <= '0;
      cfg.closed_pulse      <= '0;
      cfg.calibration_valid <= 1'b0;
      cfg.open_delay        <= OPEN_DELAY_RST;
      cfg.close_delay       <= CLOSE_DELAY_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_OPEN_PULSE:   cfg.open_pulse        <= cfg_data[PULSE_W-1:0];
        REG_CLOSED_PULSE: cfg.closed_pulse      <= cfg_data[PULSE_W-1:0];
        REG_CAL_VALID:    cfg.calibration_valid <= cfg_data[0];
        REG_OPEN_DELAY:   cfg.open_delay        <= cfg_data[DELAY_W-1:0];
        REG_CLOSE_DELAY:  cfg.close_delay       <= cfg_data[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* rtl/spsl_target.sv */
// ----------------------------------------------------------------------------
// spsl_target
// Three-stage pipeline that turns a requested position into a target pulse:
// input register, reciprocal step division, then offset and target.
// ----------------------------------------------------------------------------
module spsl_target #(
  parameter int POSITIONS = spsl_pkg::POSITIONS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_opcode,
  input  logic [spsl_pkg::POS_W-1:0]  in_pos,
  input  spsl_pkg::cfg_t              cfg,
  output spsl_pkg::cmd_t              cmd,
  input  logic                        cmd_ready
);
  import spsl_pkg::*;

  // Division by the position count minus one as a reciprocal multiply.
  // With the shift at pulse width plus log2 of the count the quotient is
  // exact for every 16-bit magnitude, so no correction step is needed.
  localparam int DIVISOR     = POSITIONS - 1;
  localparam int RECIP_SHIFT = PULSE_W + $clog2(POSITIONS);
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int PROD_W      = PULSE_W + RECIP_W;
  localparam int OFF_W       = PULSE_W + POS_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((longint'(1) << RECIP_SHIFT) + longint'(DIVISOR) - 1) / longint'(DIVISOR));
  localparam logic [POS_W:0]   POS_COUNT = (POS_W+1)'(POSITIONS);
  localparam logic [POS_W-1:0] POS_LAST  = POS_W'(POSITIONS - 1);

  // Stage registers
  logic               v1, op1;
  logic [POS_W-1:0]   pos1;
  logic               v2, op2, neg2, last2;
  logic [POS_W-1:0]   pos2;
  logic [PULSE_W-1:0] quot2;
  logic               v3, op3, inc3;
  logic [PULSE_W-1:0] target3;

  logic               free1, free2, free3;
  logic [PULSE_W:0]   diff1, mag_full1;
  logic               neg1;
  logic [PULSE_W-1:0] mag1, quot1;
  logic [PROD_W-1:0]  prod1;
  logic [POS_W-1:0]   pos_c1;
  logic [OFF_W-1:0]   off_full2;
  logic [PULSE_W-1:0] off2, target2;
  logic               inc2;

  // Each stage moves on when the one after it is empty or moving on
  assign free3    = !v3 || cmd_ready;
  assign free2    = !v2 || free3;
  assign free1    = !v1 || free2;
  assign in_ready = free1;

  // Stage 1: span sign and magnitude, reciprocal product, index clamp
  always_comb begin
    diff1     = {1'b0, cfg.open_pulse} - {1'b0, cfg.closed_pulse};
    neg1      = diff1[PULSE_W];
    mag_full1 = neg1 ? (~diff1 + (PULSE_W+1)'(1)) : diff1;
    mag1      = mag_full1[PULSE_W-1:0];
    prod1     = PROD_W'(mag1) * PROD_W'(RECIP);
    quot1     = prod1[RECIP_SHIFT +: PULSE_W];
    pos_c1    = ({1'b0, pos1} >= POS_COUNT) ? POS_LAST : pos1;
  end

  // Stage 2: offset of the position and target pulse, wrapped to 16 bits
  always_comb begin
    off_full2 = OFF_W'(quot2) * OFF_W'(pos2);
    off2      = off_full2[PULSE_W-1:0];
    if (last2) begin
      target2 = cfg.open_pulse;
    end else if (neg2) begin
      target2 = cfg.closed_pulse - off2;
    end else begin
      target2 = cfg.closed_pulse + off2;
    end
    inc2 = !neg2 && (quot2 != '0);
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (free1) v1 <= in_valid;
      if (free2) v2 <= v1;
      if (free3) v3 <= v2;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && free1) begin
      op1  <= in_opcode;
      pos1 <= in_pos;
    end
    if (v1 && free2) begin
      op2   <= op1;
      pos2  <= pos_c1;
      last2 <= (pos_c1 == POS_LAST);
      neg2  <= neg1;
      quot2 <= quot1;
    end
    if (v2 && free3) begin
      op3     <= op2;
      target3 <= target2;
      inc3    <= inc2;
    end
  end

  assign cmd.valid   = v3;
  assign cmd.opcode  = op3;
  assign cmd.target  = target3;
  assign cmd.span_up = inc3;

endmodule

/* rtl/spsl_slew.sv */
// ----------------------------------------------------------------------------
// spsl_slew
// Slew state and result register: takes a new target or a tick, steps the
// pulse by one count on schedule and presents the status of each item.
// ----------------------------------------------------------------------------
module spsl_slew (
  input  logic                          clk,
  input  logic                          rst,
  input  spsl_pkg::cmd_t                cmd,
  output logic                          cmd_ready,
  input  spsl_pkg::cfg_t                cfg,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [spsl_pkg::PULSE_W-1:0]  pulse,
  output logic                          moving,
  output logic                          rejected
);
  import spsl_pkg::*;

  logic [PULSE_W-1:0] current_pulse, current_pulse_next;
  logic [PULSE_W-1:0] target_pulse, target_pulse_next;
  logic [DELAY_W-1:0] delay_count, delay_count_next;
  logic [DELAY_W-1:0] step_delay, step_delay_next;
  logic               rejected_next;
  logic [DELAY_W-1:0] dly;
  logic               up, opening, fire;

  // One count toward the target
  function automatic logic [PULSE_W-1:0] step_toward(
    input logic [PULSE_W-1:0] cur,
    input logic [PULSE_W-1:0] tgt
  );
    logic [PULSE_W-1:0] res;
    if (cur < tgt) begin
      res = cur + PULSE_W'(1);
    end else if (cur > tgt) begin
      res = cur - PULSE_W'(1);
    end else begin
      res = cur;
    end
    return res;
  endfunction

  assign cmd_ready = !out_valid || out_ready;
  assign fire      = cmd.valid && cmd_ready;

  // Next state for the item at the head of the pipeline
  always_comb begin
    current_pulse_next = current_pulse;
    target_pulse_next  = target_pulse;
    delay_count_next   = delay_count;
    step_delay_next    = step_delay;
    rejected_next      = 1'b0;
    up                 = 1'b0;
    opening            = 1'b0;
    dly                = '0;
    if (cmd.opcode == OP_SET) begin
      if (!cfg.calibration_valid) begin
        rejected_next = 1'b1;
      end else begin
        // Retarget, pick the delay for the direction, step at once
        target_pulse_next  = cmd.target;
        up                 = (cmd.target >= current_pulse);
        opening            = (up == cmd.span_up);
        dly                = opening ? cfg.open_delay : cfg.close_delay;
        if (dly == '0) dly = DELAY_W'(1);
        step_delay_next    = dly;
        delay_count_next   = dly;
        current_pulse_next = step_toward(current_pulse, cmd.target);
      end
    end else if (current_pulse != target_pulse) begin
      // Count the tick down, step when the delay has run out
      if (delay_count > DELAY_W'(1)) begin
        delay_count_next = delay_count - DELAY_W'(1);
      end else begin
        current_pulse_next = step_toward(current_pulse, target_pulse);
        delay_count_next   = (step_delay == '0) ? DELAY_W'(1) : step_delay;
      end
    end
  end

  // Slew state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      current_pulse <= '0;
      target_pulse  <= '0;
      delay_count   <= '0;
      step_delay    <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (fire) begin
        current_pulse <= current_pulse_next;
        target_pulse  <= target_pulse_next;
        delay_count   <= delay_count_next;
        step_delay    <= step_delay_next;
      end
      if (cmd_ready) out_valid <= cmd.valid;
    end
  end

  // Status flags of the result
  always_ff @(posedge clk) begin
    if (fire) begin
      moving   <= (current_pulse_next != target_pulse_next);
      rejected <= rejected_next;
    end
  end

  assign pulse = current_pulse;

endmodule

/* test/tb_servo_position_slew_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_servo_position_slew_core
// Self-checking bench for the servo position slew core.
// ----------------------------------------------------------------------------
// Ticks and set-position commands go in on the input stream. A local model of
// the slew state predicts every result item, and the results are checked in
// order. Directed tests cover the uncalibrated core, the position table and
// clamping, a reversed span, zero and maximum delays and the pulse extremes.
// Random sessions then recalibrate near the current pulse and run set commands
// followed by tick runs, under three different stall patterns on both streams.
module tb_servo_position_slew_core;
  import spsl_pkg::*;

  localparam int POSITIONS = POSITIONS_DEF;

  typedef struct packed {
    logic [PULSE_W-1:0] pulse;
    logic               moving;
    logic               rejected;
  } slew_result_t;

  logic                    clk;
  logic                    rst;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  logic [IN_TDATA_W-1:0]   s_axis_tdata;   // [3:0] position_index
  logic [IN_TUSER_W-1:0]   s_axis_tuser;   // [0] opcode
  logic                    m_axis_tvalid;
  logic                    m_axis_tready;
  logic [OUT_TDATA_W-1:0]  m_axis_tdata;   // [15:0] pulse_value, [16] moving, [17] rejected
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;

  // Calibration and delay registers as last written
  logic [PULSE_W-1:0] cal_open;
  logic [PULSE_W-1:0] cal_closed;
  logic               cal_ok;
  logic [DELAY_W-1:0] open_wait;
  logic [DELAY_W-1:0] close_wait;

  // Slew state
  logic [PULSE_W-1:0] slew_cur;
  logic [PULSE_W-1:0] slew_target;
  logic [DELAY_W-1:0] step_wait;
  logic [DELAY_W-1:0] step_reload;

  slew_result_t pending_pulses[$];
  int           fail_count;
  int           send_idle_pct;
  int           recv_idle_pct;

  servo_position_slew_core #(
    .POSITIONS(POSITIONS)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Move the pulse one count toward the target
  function automatic void step_once();
    if (slew_cur < slew_target) begin
      slew_cur = slew_cur + 16'd1;
    end else if (slew_cur > slew_target) begin
      slew_cur = slew_cur - 16'd1;
    end
  endfunction

  // Advance the slew state by one item and give the result it causes
  function automatic slew_result_t predict_slew(input logic op, input logic [POS_W-1:0] pos);
    slew_result_t       res;
    int                 open_i;
    int                 closed_i;
    int                 span_step;
    int                 idx;
    logic               opening;
    logic [DELAY_W-1:0] dly;
    res.rejected = 1'b0;
    if (op == OP_SET) begin
      if (!cal_ok) begin
        res.rejected = 1'b1;
      end else begin
        open_i    = cal_open;
        closed_i  = cal_closed;
        span_step = (open_i - closed_i) / (POSITIONS - 1);
        idx       = pos;
        if (idx >= POSITIONS) idx = POSITIONS - 1;
        if (idx == POSITIONS - 1) begin
          slew_target = cal_open;
        end else begin
          slew_target = PULSE_W'(closed_i + span_step * idx);
        end
        // Opening is the direction of the span; an empty span counts as closing upwards
        opening = ((slew_target >= slew_cur) == (span_step > 0));
        dly = opening ? open_wait : close_wait;
        if (dly == 0) dly = 1;
        step_reload = dly;
        step_wait   = dly;
        step_once();
      end
    end else if (slew_cur != slew_target) begin
      if (step_wait > 1) begin
        step_wait = step_wait - 1'b1;
      end else begin
        step_once();
        step_wait = (step_reload == 0) ? 8'd1 : step_reload;
      end
    end
    res.pulse  = slew_cur;
    res.moving = (slew_cur != slew_target);
    return res;
  endfunction

  // Send one item, with a random gap before it
  task automatic send_item(input logic op, input logic [POS_W-1:0] pos);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_TDATA_W-POS_W){1'b0}}, pos};
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    pending_pulses.push_back(predict_slew(op, pos));
  endtask

  // Hold the input until every expected result has come, then let the pipe drain
  task automatic wait_until_quiet();
    s_axis_tvalid <= 1'b0;
    while (pending_pulses.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Write one register; only called while the core is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_OPEN_PULSE:   cal_open   = val;
      REG_CLOSED_PULSE: cal_closed = val;
      REG_CAL_VALID:    cal_ok     = val[0];
      REG_OPEN_DELAY:   open_wait  = val[DELAY_W-1:0];
      REG_CLOSE_DELAY:  close_wait = val[DELAY_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Ticks and commands before any calibration
  task automatic test_uncalibrated();
    send_item(OP_TICK, 4'd0);
    send_item(OP_TICK, 4'd15);
    send_item(OP_SET, 4'd0);
    send_item(OP_SET, 4'd15);
  endtask

  // Position table on an uneven span, clamping of large indexes, both delays
  task automatic test_position_table();
    wait_until_quiet();
    write_reg(REG_CLOSED_PULSE, 16'd0);
    write_reg(REG_OPEN_PULSE, 16'd19);
    write_reg(REG_OPEN_DELAY, 16'd1);
    write_reg(REG_CLOSE_DELAY, 16'd3);
    write_reg(REG_CAL_VALID, 16'd1);
    send_item(OP_SET, 4'd15);
    send_item(OP_TICK, 4'd5);
    send_item(OP_TICK, 4'd10);
    send_item(OP_SET, 4'd4);
    send_item(OP_TICK, 4'd0);
    send_item(OP_SET, 4'd0);
    repeat (4) send_item(OP_TICK, 4'd9);
  endtask

  // Open below closed, an empty span and zero delays
  task automatic test_reversed_span();
    wait_until_quiet();
    write_reg(REG_CLOSED_PULSE, 16'd20);
    write_reg(REG_OPEN_PULSE, 16'd0);
    write_reg(REG_OPEN_DELAY, 16'd0);
    write_reg(REG_CLOSE_DELAY, 16'd0);
    send_item(OP_SET, 4'd9);
    send_item(OP_SET, 4'd1);
    repeat (3) send_item(OP_TICK, 4'd3);
    wait_until_quiet();
    write_reg(REG_CLOSED_PULSE, 16'd5);
    write_reg(REG_OPEN_PULSE, 16'd5);
    send_item(OP_SET, 4'd3);
    send_item(OP_TICK, 4'd12);
  endtask

  // Pulse extremes, maximum delays and a reject while still moving
  task automatic test_pulse_extremes();
    wait_until_quiet();
    write_reg(REG_OPEN_PULSE, 16'hFFFF);
    write_reg(REG_CLOSED_PULSE, 16'hFFED);
    write_reg(REG_OPEN_DELAY, 16'd255);
    write_reg(REG_CLOSE_DELAY, 16'd255);
    send_item(OP_SET, 4'd9);
    send_item(OP_TICK, 4'd1);
    wait_until_quiet();
    write_reg(REG_CLOSED_PULSE, 16'hFFFF);
    write_reg(REG_OPEN_PULSE, 16'd0);
    send_item(OP_SET, 4'd5);
    send_item(OP_TICK, 4'd2);
    wait_until_quiet();
    write_reg(REG_CAL_VALID, 16'd0);
    send_item(OP_SET, 4'd2);
    send_item(OP_TICK, 4'd7);
  endtask

  // Pulse value near a base, now and then anywhere in the range
  function automatic logic [PULSE_W-1:0] near_pulse(input logic [PULSE_W-1:0] base);
    int v;
    if ($urandom_range(9) == 0) return PULSE_W'($urandom);
    v = base;
    v = v + $urandom_range(80);
    v = v - 40;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return PULSE_W'(v);
  endfunction

  // Delay register value: mostly short, sometimes zero or the maximum
  function automatic logic [CFG_DATA_W-1:0] pick_delay();
    int r;
    r = $urandom_range(19);
    if (r == 0) return 16'd0;
    if (r == 1) return 16'd255;
    return CFG_DATA_W'($urandom_range(1, 4));
  endfunction

  // Sessions of recalibration followed by commands and tick runs
  task automatic test_random_traffic(input int s_pct, input int r_pct, input int n_items);
    int sent;
    int in_session;
    int run_len;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    sent = 0;
    while (sent < n_items) begin
      wait_until_quiet();
      write_reg(REG_CLOSED_PULSE, near_pulse(slew_cur));
      write_reg(REG_OPEN_PULSE, near_pulse(slew_cur));
      write_reg(REG_OPEN_DELAY, pick_delay());
      write_reg(REG_CLOSE_DELAY, pick_delay());
      write_reg(REG_CAL_VALID, ($urandom_range(7) != 0) ? 16'd1 : 16'd0);
      in_session = 0;
      while (in_session < 40) begin
        if ($urandom_range(9) == 0) begin
          // Stray item of either kind
          send_item(1'($urandom), POS_W'($urandom));
          in_session++;
        end else begin
          send_item(OP_SET, POS_W'($urandom));
          in_session++;
          run_len = $urandom_range(24);
          repeat (run_len) begin
            send_item(OP_TICK, POS_W'($urandom));
            in_session++;
          end
        end
        if ($urandom_range(29) == 0) wait_until_quiet();
      end
      sent += in_session;
    end
  endtask

  // Stall the result stream at random
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each result item with the oldest prediction
  always @(posedge clk) begin
    slew_result_t want;
    slew_result_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.pulse    = m_axis_tdata[PULSE_W-1:0];
      got.moving   = m_axis_tdata[PULSE_W];
      got.rejected = m_axis_tdata[PULSE_W+1];
      if (pending_pulses.size() == 0) begin
        $display("%0t: unexpected result pulse=%0d moving=%0b rejected=%0b",
                 $time, got.pulse, got.moving, got.rejected);
        fail_count++;
      end else begin
        want = pending_pulses.pop_front();
        if (got !== want) begin
          $display({"%0t: mismatch expected pulse=%0d moving=%0b rejected=%0b,",
                    " got pulse=%0d moving=%0b rejected=%0b"},
                   $time, want.pulse, want.moving, want.rejected,
                   got.pulse, got.moving, got.rejected);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("[servo_position_slew_core] ERROR");
    $finish;
  end

  initial begin
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    m_axis_tready <= 1'b0;
    cfg_valid     <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    fail_count    = 0;
    send_idle_pct = 9;
    recv_idle_pct = 64;
    cal_open      = '0;
    cal_closed    = '0;
    cal_ok        = 1'b0;
    open_wait     = OPEN_DELAY_RST;
    close_wait    = CLOSE_DELAY_RST;
    slew_cur      = '0;
    slew_target   = '0;
    step_wait     = '0;
    step_reload   = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_uncalibrated();
    test_position_table();
    test_reversed_span();
    test_pulse_extremes();
    test_random_traffic(9, 64, 250);
    test_random_traffic(64, 9, 250);
    test_random_traffic(0, 0, 250);

    // Drain and wait for anything stray
    wait_until_quiet();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("[servo_position_slew_core] OK");
    end else begin
      $display("[servo_position_slew_core] ERROR");
    end
    $finish;
  end

endmodule
